// File: sv/fcca_pkg.sv
// Package for the cluster chain allocator: item types, field widths, status codes.
`default_nettype none

package fcca_pkg;

    localparam int FAT_ENTRIES_DEF = 4096;
    localparam int BLOCK_BYTES_DEF = 512;

    localparam int SIZE_W = 21;
    localparam int CLUS_W = 12;
    localparam int STAT_W = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_USED = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] size_bytes;
        logic [CLUS_W-1:0] start_cluster;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CLUS_W-1:0] first_cluster;
        logic [CLUS_W-1:0] cluster_count;
        logic [CLUS_W-1:0] free_clusters;
    } rsp_t;

endpackage

`default_nettype wire

// File: sv/fat_cluster_chain_allocator.sv
// Cluster chain allocator top level: table memory, block count multiplier, scan and walk sequencer.
//
//  channel | handshake          | payload | carries
//  --------+--------------------+---------+-----------------------------------
//  req     | req_valid/req_stall| req_t   | allocate size or chain head to free
//  rsp     | rsp_valid/rsp_stall| rsp_t   | status, head, count, free clusters
//
// Allocate: accept, reciprocal multiply, check, scan, finish, then response; the scan reads
//   entries from index 0 up to the last cluster taken. Zero size or no space skip scan and finish.
// Free: walks the chain clearing each cluster, and stops on a free link, an end mark or a backward link.
// After reset a clearing pass zeroes the table; req is stalled until it ends.
// One item at a time; the result register lets the next item in while rsp is stalled.
`default_nettype none

module fat_cluster_chain_allocator #(
    parameter int FAT_ENTRIES = fcca_pkg::FAT_ENTRIES_DEF,
    parameter int BLOCK_BYTES = fcca_pkg::BLOCK_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fcca_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fcca_pkg::rsp_t rsp
);
    import fcca_pkg::*;

    localparam int IDX_W  = $clog2(FAT_ENTRIES);
    localparam int DIV_W  = SIZE_W + 1;
    localparam int RCP_W  = DIV_W + 1;
    localparam int RCP_SH = DIV_W + $clog2(BLOCK_BYTES);
    localparam int CW     = (IDX_W > DIV_W) ? IDX_W : DIV_W;
    localparam int SW     = (IDX_W > CLUS_W) ? IDX_W : CLUS_W;

    localparam longint RCP_FULL = ((longint'(1) << RCP_SH) + longint'(BLOCK_BYTES - 1))
                                  / longint'(BLOCK_BYTES);

    localparam logic [IDX_W-1:0] END_MARK = IDX_W'(FAT_ENTRIES - 1);
    localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_FULL);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_FREE  = 3'd6;
    localparam logic [2:0] ST_RESP  = 3'd7;

    logic [IDX_W-1:0] mem [FAT_ENTRIES];

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]  free_total_reg, free_total_next;
    logic              out_vld_reg, out_vld_next;
    rsp_t              out_reg, out_next;
    rsp_t              res_reg, res_next;

    logic [DIV_W-1:0]  dq_reg, dq_next;

    logic [IDX_W-1:0]  need_reg, need_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic [IDX_W-1:0]  taken_reg, taken_next;
    logic [IDX_W-1:0]  first_reg, first_next;

    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic              walk_first_reg, walk_first_next;

    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [IDX_W-1:0]  mem_wd;

    logic [DIV_W+RCP_W-1:0] div_prod;
    logic [IDX_W-1:0]  walk_cnt;
    logic [IDX_W:0]    free_sum;
    logic [IDX_W-1:0]  free_add;

    assign div_prod = {{RCP_W{1'b0}}, dq_reg} * {{DIV_W{1'b0}}, RCP};
    assign walk_cnt = (rd_data_reg == '0) ? count_reg : IDX_W'(count_reg + 1'b1);
    assign free_sum = {1'b0, free_total_reg} + {1'b0, walk_cnt};
    assign free_add = (free_sum > {1'b0, END_MARK}) ? END_MARK : free_sum[IDX_W-1:0];

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_total_next = free_total_reg;
        out_vld_next    = out_vld_reg && rsp_stall;
        out_next        = out_reg;
        res_next        = res_reg;
        dq_next         = dq_reg;
        need_next       = need_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        taken_next      = taken_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        walk_first_next = walk_first_reg;
        rd_addr         = scan_idx_reg;
        mem_we          = 1'b0;
        mem_wa          = clr_idx_reg;
        mem_wd          = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_idx_reg;
                clr_idx_next = IDX_W'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == END_MARK)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rd_addr = IDX_W'(req.start_cluster);
                if (req_valid)
                begin
                    if (req.kind == KIND_ALLOC)
                    begin
                        dq_next    = DIV_W'(req.size_bytes) + DIV_W'(BLOCK_BYTES - 1);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cur_next        = IDX_W'(req.start_cluster);
                        count_next      = '0;
                        walk_first_next = 1'b1;
                        if (SW'(req.start_cluster) >= SW'(END_MARK))
                        begin
                            res_next = '{status: STAT_NOT_USED,
                                         first_cluster: CLUS_W'(END_MARK),
                                         cluster_count: '0,
                                         free_clusters: CLUS_W'(free_total_reg)};
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_FREE;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                dq_next    = DIV_W'(div_prod >> RCP_SH);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (dq_reg == '0)
                begin
                    res_next = '{status: STAT_OK,
                                 first_cluster: CLUS_W'(END_MARK),
                                 cluster_count: '0,
                                 free_clusters: CLUS_W'(free_total_reg)};
                    state_next = ST_RESP;
                end
                else if (CW'(dq_reg) > CW'(free_total_reg))
                begin
                    res_next = '{status: STAT_NO_SPACE,
                                 first_cluster: CLUS_W'(END_MARK),
                                 cluster_count: '0,
                                 free_clusters: CLUS_W'(free_total_reg)};
                    state_next = ST_RESP;
                end
                else
                begin
                    need_next      = IDX_W'(dq_reg);
                    scan_idx_next  = '0;
                    taken_next     = '0;
                    have_prev_next = 1'b0;
                    first_next     = END_MARK;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg != END_MARK)
                begin
                    rd_addr       = scan_idx_reg;
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_idx_reg;
                    scan_idx_next = IDX_W'(scan_idx_reg + 1'b1);
                end
                if (rd_vld_reg && rd_data_reg == '0)
                begin
                    if (have_prev_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wa = prev_reg;
                        mem_wd = rd_idx_reg;
                    end
                    else
                    begin
                        first_next = rd_idx_reg;
                    end
                    prev_next      = rd_idx_reg;
                    have_prev_next = 1'b1;
                    taken_next     = IDX_W'(taken_reg + 1'b1);
                    if (IDX_W'(taken_reg + 1'b1) == need_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else if (!rd_vld_reg && scan_idx_reg == END_MARK)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (have_prev_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = prev_reg;
                    mem_wd = END_MARK;
                end
                free_total_next = IDX_W'(free_total_reg - taken_reg);
                res_next = '{status: STAT_OK,
                             first_cluster: CLUS_W'(first_reg),
                             cluster_count: CLUS_W'(taken_reg),
                             free_clusters: CLUS_W'(free_total_reg - taken_reg)};
                state_next = ST_RESP;
            end
            ST_FREE:
            begin
                if (rd_data_reg == '0)
                begin
                    if (walk_first_reg)
                    begin
                        res_next = '{status: STAT_NOT_USED,
                                     first_cluster: CLUS_W'(END_MARK),
                                     cluster_count: '0,
                                     free_clusters: CLUS_W'(free_total_reg)};
                    end
                    else
                    begin
                        free_total_next = free_add;
                        res_next = '{status: STAT_OK,
                                     first_cluster: CLUS_W'(END_MARK),
                                     cluster_count: CLUS_W'(walk_cnt),
                                     free_clusters: CLUS_W'(free_add)};
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wa          = cur_reg;
                    mem_wd          = '0;
                    count_next      = walk_cnt;
                    walk_first_next = 1'b0;
                    if (rd_data_reg >= END_MARK || rd_data_reg <= cur_reg)
                    begin
                        free_total_next = free_add;
                        res_next = '{status: STAT_OK,
                                     first_cluster: CLUS_W'(END_MARK),
                                     cluster_count: CLUS_W'(walk_cnt),
                                     free_clusters: CLUS_W'(free_add)};
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        rd_addr  = rd_data_reg;
                        cur_next = rd_data_reg;
                    end
                end
            end
            ST_RESP:
            begin
                if (!out_vld_reg || !rsp_stall)
                begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            free_total_reg <= END_MARK;
            out_vld_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_total_reg <= free_total_next;
            out_vld_reg    <= out_vld_next;
            rd_vld_reg     <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        res_reg        <= res_next;
        dq_reg         <= dq_next;
        need_reg       <= need_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        prev_reg       <= prev_next;
        have_prev_reg  <= have_prev_next;
        taken_reg      <= taken_next;
        first_reg      <= first_next;
        cur_reg        <= cur_next;
        count_reg      <= count_next;
        walk_first_reg <= walk_first_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= END_MARK)
        else $error("free cluster total above table capacity");

    a_scan_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (taken_reg < need_reg))
        else $error("scan kept running after enough clusters taken");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == ST_RESP))
        else $error("result raised outside response state");

endmodule

`default_nettype wire

// File: tb/fat_cluster_chain_allocator_test.sv
// Self-checking testbench for the cluster chain allocator: directed cases, then random traffic.
module fat_cluster_chain_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fcca_pkg::*;

    localparam int FAT_ENTRIES = FAT_ENTRIES_DEF;
    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
    localparam int IDX_W       = $clog2(FAT_ENTRIES);
    localparam int END_MARK    = FAT_ENTRIES - 1;
    localparam int SIZE_MAX    = (1 << SIZE_W) - 1;
    localparam int SIZE_FULL   = END_MARK * BLOCK_BYTES;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int errors = 0;

    // predicted allocation table and free count
    logic [CLUS_W-1:0] cluster_map [FAT_ENTRIES];
    int free_left;

    rsp_t pending_rsps[$];
    logic [CLUS_W-1:0] live_heads[$];
    logic [CLUS_W-1:0] pair_head;
    rsp_t got_want;

    fat_cluster_chain_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    function automatic rsp_t predict_alloc(input logic [SIZE_W-1:0] size);
        rsp_t r;
        int blocks;
        int got;
        int prev;
        int i;
        blocks = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        r.status = STAT_OK;
        r.first_cluster = CLUS_W'(END_MARK);
        r.cluster_count = '0;
        if (blocks > free_left)
        begin
            r.status = STAT_NO_SPACE;
        end
        else if (blocks > 0)
        begin
            got = 0;
            prev = -1;
            for (i = 0; i < END_MARK && got < blocks; i++)
            begin
                if (cluster_map[IDX_W'(i)] == '0)
                begin
                    cluster_map[IDX_W'(i)] = CLUS_W'(END_MARK);
                    if (prev < 0)
                        r.first_cluster = CLUS_W'(i);
                    else
                        cluster_map[IDX_W'(prev)] = CLUS_W'(i);
                    prev = i;
                    got++;
                end
            end
            free_left -= got;
            r.cluster_count = CLUS_W'(got);
        end
        r.free_clusters = CLUS_W'(free_left);
        return r;
    endfunction

    function automatic rsp_t predict_free(input logic [CLUS_W-1:0] start);
        rsp_t r;
        int cur;
        int nxt;
        int freed;
        bit done;
        r.status = STAT_NOT_USED;
        r.first_cluster = CLUS_W'(END_MARK);
        r.cluster_count = '0;
        if (int'(start) < END_MARK && cluster_map[IDX_W'(start)] != '0)
        begin
            r.status = STAT_OK;
            cur = int'(start);
            freed = 0;
            done = 1'b0;
            while (!done)
            begin
                nxt = int'(cluster_map[IDX_W'(cur)]);
                cluster_map[IDX_W'(cur)] = '0;
                freed++;
                if (nxt == 0 || nxt >= END_MARK || nxt <= cur)
                    done = 1'b1;
                else if (cluster_map[IDX_W'(nxt)] == '0)
                    done = 1'b1;
                else
                    cur = nxt;
            end
            free_left += freed;
            if (free_left > END_MARK)
                free_left = END_MARK;
            r.cluster_count = CLUS_W'(freed);
        end
        r.free_clusters = CLUS_W'(free_left);
        return r;
    endfunction

    task automatic send_item(input req_t item, output rsp_t predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        if (item.kind == KIND_ALLOC)
            predicted = predict_alloc(item.size_bytes);
        else
            predicted = predict_free(item.start_cluster);
        pending_rsps = {pending_rsps, predicted};
    endtask

    task automatic send_alloc(input int size, output rsp_t predicted);
        req_t item;
        item.kind = KIND_ALLOC;
        item.size_bytes = SIZE_W'(size);
        item.start_cluster = CLUS_W'($urandom);
        send_item(item, predicted);
    endtask

    task automatic send_free(input int start, output rsp_t predicted);
        req_t item;
        item.kind = KIND_FREE;
        item.size_bytes = SIZE_W'($urandom);
        item.start_cluster = CLUS_W'(start);
        send_item(item, predicted);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsps.size() != 0);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_rsps.size() == 0)
            begin
                $display("%0t: unexpected item expected none got %p", $time, rsp);
                errors++;
            end
            else
            begin
                got_want = pending_rsps.pop_front();
                check_field("status", int'(got_want.status), int'(rsp.status));
                check_field("first_cluster", int'(got_want.first_cluster),
                            int'(rsp.first_cluster));
                check_field("cluster_count", int'(got_want.cluster_count),
                            int'(rsp.cluster_count));
                check_field("free_clusters", int'(got_want.free_clusters),
                            int'(rsp.free_clusters));
            end
        end
    end

    task automatic test_small_allocs();
        rsp_t p;
        send_alloc(0, p);
        send_alloc(1, p);
        send_alloc(BLOCK_BYTES, p);
        send_alloc(BLOCK_BYTES + 1, p);
        pair_head = p.first_cluster;
        send_alloc(SIZE_MAX, p);
    endtask

    task automatic test_bad_frees();
        rsp_t p;
        send_free(END_MARK, p);
        send_free(100, p);
        send_free(0, p);
        send_free(0, p);
    endtask

    // freeing mid-chain leaves a dangling head; a stale link can run into a newer chain
    task automatic test_dangling_chain();
        rsp_t p;
        logic [CLUS_W-1:0] head;
        send_alloc(3 * BLOCK_BYTES, p);
        head = p.first_cluster;
        send_free(int'(cluster_map[IDX_W'(head)]), p);
        send_free(int'(head), p);
        send_free(int'(cluster_map[IDX_W'(pair_head)]), p);
        send_alloc(2 * BLOCK_BYTES, p);
        head = p.first_cluster;
        send_free(int'(pair_head), p);
        send_free(int'(head), p);
    endtask

    task automatic test_full_table();
        rsp_t p;
        int i;
        wait_drained();
        for (i = 0; i < END_MARK; i++)
        begin
            if (cluster_map[IDX_W'(i)] != '0)
                send_free(i, p);
        end
        send_alloc(SIZE_FULL, p);
        send_alloc(1, p);
        send_alloc(0, p);
        send_free(END_MARK - 1, p);
        send_alloc(BLOCK_BYTES, p);
        send_free(0, p);
        send_free(END_MARK - 1, p);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        rsp_t p;
        int n;
        int r;
        int k;
        int probe;
        wait_drained();
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                send_alloc($urandom_range(0, 8 * BLOCK_BYTES), p);
                if (p.status == STAT_OK && p.cluster_count != '0)
                    live_heads = {live_heads, p.first_cluster};
            end
            else if (r < 44)
            begin
                send_alloc($urandom_range(0, SIZE_MAX), p);
                if (p.status == STAT_OK && p.cluster_count != '0)
                    live_heads = {live_heads, p.first_cluster};
            end
            else if (r < 75 && live_heads.size() != 0)
            begin
                k = $urandom_range(0, live_heads.size() - 1);
                probe = int'(live_heads[k]);
                live_heads.delete(k);
                send_free(probe, p);
            end
            else if (r < 88)
            begin
                // try to hit an in-use cluster in the low 512 entries, often inside a live chain
                probe = $urandom_range(0, 511);
                for (k = 0; k < 16 && cluster_map[IDX_W'(probe)] == '0; k++)
                    probe = $urandom_range(0, 511);
                send_free(probe, p);
            end
            else
            begin
                send_free($urandom_range(0, END_MARK), p);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < FAT_ENTRIES; i++)
            cluster_map[IDX_W'(i)] = '0;
        free_left = END_MARK;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_small_allocs();
        test_bad_frees();
        test_dangling_chain();
        test_full_table();
        test_random_traffic(29, 0, 0);
        test_random_traffic(29, 46, 0);
        test_random_traffic(29, 0, 46);
        test_random_traffic(29, 6, 6);
        wait_drained();
        repeat (FAT_ENTRIES + 64) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
